// ===== rtl/http_byte_range_parser_defines.svh =====
// Assertion macros shared by the checker of the HTTP byte range parser.
`ifndef HTTP_BYTE_RANGE_PARSER_DEFINES_SVH
`define HTTP_BYTE_RANGE_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define HBRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hbrp assertion failed");

// Next-cycle implication, disabled while reset is active.
`define HBRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hbrp assertion failed");

`endif

// ===== rtl/hbrp_pkg.sv =====
// Package with types, constants and the digit step of the HTTP byte range parser.
package hbrp_pkg;

    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 3;

    localparam logic [POS_W-1:0] PREFIX_LEN = 3'd6;

    localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [STATUS_W-1:0] ST_NOT_RANGE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNSAT     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd3;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               nonempty;
        logic               invalid;
    } t_tok;

    typedef struct packed {
        logic               is_range;
        t_tok               first;
        t_tok               second;
        logic [VALUE_W-1:0] size;
    } t_snap;

    // Expected byte of the "bytes=" prefix at a given position.
    function automatic logic [CHAR_W-1:0] prefix_char(logic [POS_W-1:0] pos);
        logic [CHAR_W-1:0] c;
        case (pos)
            3'd0:    c = 8'h62;
            3'd1:    c = 8'h79;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h65;
            3'd4:    c = 8'h73;
            3'd5:    c = 8'h3D;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // One decimal digit step: value * 10 + digit, with overflow and syntax checks.
    function automatic t_tok take_digit(t_tok tok, logic [CHAR_W-1:0] c);
        t_tok               r;
        logic [VALUE_W+3:0] wide;
        logic [VALUE_W+3:0] prod;
        r          = tok;
        r.nonempty = 1'b1;
        wide       = {4'b0000, tok.value};
        prod       = (wide << 3) + (wide << 1) + {{VALUE_W{1'b0}}, c[3:0]};
        if (!tok.invalid) begin
            if (c < CHAR_ZERO || c > CHAR_NINE) begin
                r.invalid = 1'b1;
            end else if (prod[VALUE_W+3:VALUE_W] != 4'b0000) begin
                r.invalid = 1'b1;
            end else begin
                r.value = prod[VALUE_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/hbrp_if.sv =====
// Channel interfaces for header bytes in and range results out.
interface hbrp_in_if;
    import hbrp_pkg::*;

    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  header_char;
    logic               has_char;
    logic               last_char;
    logic [VALUE_W-1:0] content_size;

    modport source (output valid, header_char, has_char, last_char, content_size,
                    input ready);
    modport sink (input valid, header_char, has_char, last_char, content_size,
                  output ready);
endinterface

interface hbrp_out_if;
    import hbrp_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] range_status;
    logic [VALUE_W-1:0]  range_start;
    logic [VALUE_W-1:0]  range_end;

    modport source (output valid, range_status, range_start, range_end, input ready);
    modport sink (input valid, range_status, range_start, range_end, output ready);
endinterface

// ===== rtl/http_byte_range_parser.sv =====
// HTTP Range header parser that resolves one byte range against the content size.
//
// Usage: header bytes arrive on i_hdr, one byte per transaction. The transaction
// with last_char set, or any transaction with has_char clear, ends the header;
// content_size is sampled on that transaction. Each header yields exactly one
// transaction on o_rng carrying status, inclusive start and inclusive end.
// Throughput is one header byte per cycle while i_hdr.ready is high. The byte
// register feeds the parse step, whose state update is a prefix match and a
// multiply-by-ten accumulate; headers may follow each other with no gap.
// Each result passes through the input register, the snapshot register and
// the result register before it is presented on o_rng.
// When o_rng stalls, results wait in the result and snapshot registers; bytes
// that do not end a header keep flowing, and i_hdr.ready drops only when an
// ending byte finds both registers occupied.
// Reset clears the parse state and all valid flags; no result is pending after.
module http_byte_range_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hbrp_in_if.sink           i_hdr,
    hbrp_out_if.source        o_rng
);
    import hbrp_pkg::*;

    logic               r_in_valid;
    logic [CHAR_W-1:0]  r_in_char;
    logic               r_in_has;
    logic               r_in_last;
    logic [VALUE_W-1:0] r_in_size;

    logic [POS_W-1:0]   r_prefix_pos;
    logic               r_prefix_failed;
    logic               r_comma_seen;
    logic               r_dash_seen;
    t_tok               r_first;
    t_tok               r_second;

    logic [POS_W-1:0]   n_prefix_pos;
    logic               n_prefix_failed;
    logic               n_comma_seen;
    logic               n_dash_seen;
    t_tok               n_first;
    t_tok               n_second;

    logic               r_snap_valid;
    t_snap              r_snap;
    t_snap              n_snap;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [VALUE_W-1:0]  r_out_start;
    logic [VALUE_W-1:0]  r_out_end;
    logic [STATUS_W-1:0] n_out_status;
    logic [VALUE_W-1:0]  n_out_start;
    logic [VALUE_W-1:0]  n_out_end;

    logic               out_free;
    logic               snap_free;
    logic               in_ends;
    logic               in_fire;
    logic               in_take;

    logic [VALUE_W-1:0] size_m1;
    logic [VALUE_W-1:0] suffix_len;

    assign out_free  = !r_out_valid || o_rng.ready;
    assign snap_free = !r_snap_valid || out_free;
    assign in_ends   = !r_in_has || r_in_last;
    assign in_fire   = r_in_valid && (!in_ends || snap_free);
    assign in_take   = i_hdr.valid && i_hdr.ready;

    assign i_hdr.ready        = !r_in_valid || in_fire;
    assign o_rng.valid        = r_out_valid;
    assign o_rng.range_status = r_out_status;
    assign o_rng.range_start  = r_out_start;
    assign o_rng.range_end    = r_out_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_hdr.ready) begin
            r_in_valid <= i_hdr.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_char <= i_hdr.header_char;
            r_in_has  <= i_hdr.has_char;
            r_in_last <= i_hdr.last_char;
            r_in_size <= i_hdr.content_size;
        end
    end

    always_comb begin
        n_prefix_pos    = r_prefix_pos;
        n_prefix_failed = r_prefix_failed;
        n_comma_seen    = r_comma_seen;
        n_dash_seen     = r_dash_seen;
        n_first         = r_first;
        n_second        = r_second;
        if (r_in_has && !r_prefix_failed) begin
            if (r_prefix_pos < PREFIX_LEN) begin
                if (r_in_char == prefix_char(r_prefix_pos)) begin
                    n_prefix_pos = r_prefix_pos + 3'd1;
                end else begin
                    n_prefix_failed = 1'b1;
                end
            end else if (r_in_char == CHAR_COMMA) begin
                n_comma_seen = 1'b1;
            end else if (!r_dash_seen && r_in_char == CHAR_DASH) begin
                n_dash_seen = 1'b1;
            end else if (!r_dash_seen) begin
                n_first = take_digit(r_first, r_in_char);
            end else begin
                n_second = take_digit(r_second, r_in_char);
            end
        end
        n_snap.is_range = !n_prefix_failed && (n_prefix_pos == PREFIX_LEN)
                          && !n_comma_seen && n_dash_seen;
        n_snap.first    = n_first;
        n_snap.second   = n_second;
        n_snap.size     = r_in_size;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_pos    <= '0;
            r_prefix_failed <= 1'b0;
            r_comma_seen    <= 1'b0;
            r_dash_seen     <= 1'b0;
            r_first         <= '0;
            r_second        <= '0;
        end else if (in_fire) begin
            if (in_ends) begin
                r_prefix_pos    <= '0;
                r_prefix_failed <= 1'b0;
                r_comma_seen    <= 1'b0;
                r_dash_seen     <= 1'b0;
                r_first         <= '0;
                r_second        <= '0;
            end else begin
                r_prefix_pos    <= n_prefix_pos;
                r_prefix_failed <= n_prefix_failed;
                r_comma_seen    <= n_comma_seen;
                r_dash_seen     <= n_dash_seen;
                r_first         <= n_first;
                r_second        <= n_second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (snap_free) begin
            r_snap_valid <= in_fire && in_ends;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && in_ends) begin
            r_snap <= n_snap;
        end
    end

    assign size_m1    = r_snap.size - 64'd1;
    assign suffix_len = (r_snap.second.value > r_snap.size) ? r_snap.size
                                                            : r_snap.second.value;

    always_comb begin
        n_out_status = ST_MALFORMED;
        n_out_start  = '0;
        n_out_end    = '0;
        if (!r_snap.is_range) begin
            n_out_status = ST_NOT_RANGE;
        end else if (r_snap.first.nonempty && r_snap.second.nonempty) begin
            if (r_snap.first.invalid || r_snap.second.invalid
                || r_snap.first.value > r_snap.second.value) begin
                n_out_status = ST_MALFORMED;
            end else if (r_snap.first.value >= r_snap.size) begin
                n_out_status = ST_UNSAT;
            end else begin
                n_out_status = ST_OK;
                n_out_start  = r_snap.first.value;
                n_out_end    = (r_snap.second.value < size_m1) ? r_snap.second.value
                                                               : size_m1;
            end
        end else if (r_snap.first.nonempty) begin
            if (r_snap.first.invalid) begin
                n_out_status = ST_MALFORMED;
            end else if (r_snap.first.value >= r_snap.size) begin
                n_out_status = ST_UNSAT;
            end else begin
                n_out_status = ST_OK;
                n_out_start  = r_snap.first.value;
                n_out_end    = size_m1;
            end
        end else if (r_snap.second.nonempty) begin
            if (r_snap.second.invalid || r_snap.second.value == '0) begin
                n_out_status = ST_MALFORMED;
            end else if (r_snap.size == '0) begin
                n_out_status = ST_UNSAT;
            end else begin
                n_out_status = ST_OK;
                n_out_start  = r_snap.size - suffix_len;
                n_out_end    = size_m1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_snap_valid) begin
            r_out_status <= n_out_status;
            r_out_start  <= n_out_start;
            r_out_end    <= n_out_end;
        end
    end

endmodule

// ===== rtl/hbrp_checker.sv =====
// Port-level checker of the HTTP byte range parser and its bind statement.
`include "http_byte_range_parser_defines.svh"

module hbrp_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [hbrp_pkg::STATUS_W-1:0] i_out_status,
    input  logic [hbrp_pkg::VALUE_W-1:0]  i_out_start,
    input  logic [hbrp_pkg::VALUE_W-1:0]  i_out_end
);
    import hbrp_pkg::*;

    // A stalled result transaction keeps its contents.
    `HBRP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_status) && $stable(i_out_start) && $stable(i_out_end))

    // Offsets are zero unless the range resolved.
    `HBRP_ASSERT_NOW(a_zero_unless_ok, i_clk, i_rst_n, i_out_valid && i_out_status != ST_OK, i_out_start == '0 && i_out_end == '0)

    // A resolved range is never inverted.
    `HBRP_ASSERT_NOW(a_ok_ordered, i_clk, i_rst_n, i_out_valid && i_out_status == ST_OK, i_out_start <= i_out_end)

endmodule

bind http_byte_range_parser hbrp_checker u_hbrp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_rng.valid),
    .i_out_ready  (o_rng.ready),
    .i_out_status (o_rng.range_status),
    .i_out_start  (o_rng.range_start),
    .i_out_end    (o_rng.range_end)
);

// ===== tb/sv/tb_http_byte_range_parser.sv =====
// Testbench for the HTTP byte range parser: directed and random headers checked against a predictor.
module tb_http_byte_range_parser;
    import hbrp_pkg::*;

    localparam logic [47:0] RANGE_PREFIX = "bytes=";
    localparam logic [63:0] SIZE_MAX     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          PHASE_ITEMS  = 300;
    localparam int          DRAIN_CYCLES = 10;

    typedef enum int {
        RUN_FREE  = 0,
        SRC_SLOW  = 1,
        SINK_SLOW = 2,
        BOTH_SLOW = 3
    } t_idle_mode;

    typedef struct {
        logic [CHAR_W-1:0]  ch;
        logic               has;
        logic               fin;
        logic [VALUE_W-1:0] clen;
    } t_hdr_item;

    typedef struct {
        logic [STATUS_W-1:0] rs_status;
        logic [VALUE_W-1:0]  rs_start;
        logic [VALUE_W-1:0]  rs_end;
    } t_range_res;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               seen;
        logic               bad;
    } t_dec_tok;

    logic i_clk;
    logic i_rst_n;

    hbrp_in_if  hdr_ch ();
    hbrp_out_if rng_ch ();

    http_byte_range_parser DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hdr   (hdr_ch),
        .o_rng   (rng_ch)
    );

    t_hdr_item   pending_bytes[$];
    t_range_res  expected_ranges[$];
    logic [7:0]  hdr_buf[$];
    t_idle_mode  idle_mode = RUN_FREE;
    int          items_queued = 0;
    int          items_accepted = 0;
    int          bad_results = 0;
    int          cycle_count = 0;

    logic [POS_W-1:0] pfx_matched;
    logic             pfx_broken;
    logic             saw_comma;
    logic             saw_dash;
    t_dec_tok         lo_tok;
    t_dec_tok         hi_tok;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic bit sender_rests();
        if (idle_mode == SRC_SLOW) begin
            return $urandom_range(99) < 84;
        end else if (idle_mode == BOTH_SLOW) begin
            return $urandom_range(99) < 15;
        end
        return 1'b0;
    endfunction

    function automatic bit receiver_stalls();
        if (idle_mode == SINK_SLOW) begin
            return $urandom_range(99) < 84;
        end else if (idle_mode == BOTH_SLOW) begin
            return $urandom_range(99) < 15;
        end
        return 1'b0;
    endfunction

    function automatic void clear_parser();
        pfx_matched = '0;
        pfx_broken  = 1'b0;
        saw_comma   = 1'b0;
        saw_dash    = 1'b0;
        lo_tok      = '{'0, 1'b0, 1'b0};
        hi_tok      = '{'0, 1'b0, 1'b0};
    endfunction

    function automatic t_dec_tok add_digit(t_dec_tok t, logic [7:0] c);
        t_dec_tok    r;
        logic [67:0] prod;
        r      = t;
        r.seen = 1'b1;
        if (t.bad) begin
            return r;
        end
        if (c < CHAR_ZERO || c > CHAR_NINE) begin
            r.bad = 1'b1;
            return r;
        end
        prod = 68'(t.value) * 68'd10 + 68'(c - CHAR_ZERO);
        if (prod[67:64] != 4'd0) begin
            r.bad = 1'b1;
        end else begin
            r.value = prod[63:0];
        end
        return r;
    endfunction

    function automatic void parse_byte(logic [7:0] c);
        if (pfx_broken) begin
            return;
        end
        if (pfx_matched < PREFIX_LEN) begin
            if (c == RANGE_PREFIX[47 - 8 * pfx_matched -: 8]) begin
                pfx_matched = pfx_matched + 3'd1;
            end else begin
                pfx_broken = 1'b1;
            end
        end else if (c == CHAR_COMMA) begin
            saw_comma = 1'b1;
        end else if (!saw_dash && c == CHAR_DASH) begin
            saw_dash = 1'b1;
        end else if (!saw_dash) begin
            lo_tok = add_digit(lo_tok, c);
        end else begin
            hi_tok = add_digit(hi_tok, c);
        end
    endfunction

    function automatic t_range_res resolve_range(logic [63:0] clen);
        t_range_res  r;
        logic [63:0] span;
        r.rs_status = ST_MALFORMED;
        r.rs_start  = '0;
        r.rs_end    = '0;
        if (pfx_broken || pfx_matched < PREFIX_LEN || saw_comma || !saw_dash) begin
            r.rs_status = ST_NOT_RANGE;
        end else if (lo_tok.seen && hi_tok.seen) begin
            if (!(lo_tok.bad || hi_tok.bad || lo_tok.value > hi_tok.value)) begin
                if (lo_tok.value >= clen) begin
                    r.rs_status = ST_UNSAT;
                end else begin
                    r.rs_status = ST_OK;
                    r.rs_start  = lo_tok.value;
                    r.rs_end    = (hi_tok.value < clen - 64'd1) ? hi_tok.value : clen - 64'd1;
                end
            end
        end else if (lo_tok.seen) begin
            if (!lo_tok.bad) begin
                if (lo_tok.value >= clen) begin
                    r.rs_status = ST_UNSAT;
                end else begin
                    r.rs_status = ST_OK;
                    r.rs_start  = lo_tok.value;
                    r.rs_end    = clen - 64'd1;
                end
            end
        end else if (hi_tok.seen) begin
            if (!hi_tok.bad && hi_tok.value != 64'd0) begin
                if (clen == 64'd0) begin
                    r.rs_status = ST_UNSAT;
                end else begin
                    span        = (hi_tok.value > clen) ? clen : hi_tok.value;
                    r.rs_status = ST_OK;
                    r.rs_start  = clen - span;
                    r.rs_end    = clen - 64'd1;
                end
            end
        end
        return r;
    endfunction

    // A header ends on its flagged last byte or on any transaction without a byte.
    function automatic void track_item(t_hdr_item it);
        if (it.has) begin
            parse_byte(it.ch);
        end
        if (it.has && !it.fin) begin
            return;
        end
        expected_ranges.insert(expected_ranges.size(), resolve_range(it.clen));
        clear_parser();
    endfunction

    always @(posedge i_clk) begin : drive_hdr
        t_hdr_item nxt;
        if (!i_rst_n) begin
            hdr_ch.valid <= 1'b0;
        end else begin
            if (hdr_ch.valid && hdr_ch.ready) begin
                track_item('{hdr_ch.header_char, hdr_ch.has_char, hdr_ch.last_char,
                             hdr_ch.content_size});
                items_accepted = items_accepted + 1;
            end
            if (!hdr_ch.valid || hdr_ch.ready) begin
                if (pending_bytes.size() != 0 && !sender_rests()) begin
                    nxt = pending_bytes.pop_front();
                    hdr_ch.valid        <= 1'b1;
                    hdr_ch.header_char  <= nxt.ch;
                    hdr_ch.has_char     <= nxt.has;
                    hdr_ch.last_char    <= nxt.fin;
                    hdr_ch.content_size <= nxt.clen;
                end else begin
                    hdr_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch_rng
        t_range_res want;
        if (!i_rst_n) begin
            rng_ch.ready <= 1'b0;
        end else begin
            if (rng_ch.valid && rng_ch.ready) begin
                if (expected_ranges.size() == 0) begin
                    $error("unexpected range result: status %0d start %0d end %0d",
                           rng_ch.range_status, rng_ch.range_start, rng_ch.range_end);
                    bad_results = bad_results + 1;
                end else begin
                    want = expected_ranges.pop_front();
                    if (rng_ch.range_status !== want.rs_status) begin
                        $error("range_status: expected %0d, actual %0d",
                               want.rs_status, rng_ch.range_status);
                        bad_results = bad_results + 1;
                    end
                    if (rng_ch.range_start !== want.rs_start) begin
                        $error("range_start: expected %0d, actual %0d",
                               want.rs_start, rng_ch.range_start);
                        bad_results = bad_results + 1;
                    end
                    if (rng_ch.range_end !== want.rs_end) begin
                        $error("range_end: expected %0d, actual %0d",
                               want.rs_end, rng_ch.range_end);
                        bad_results = bad_results + 1;
                    end
                end
            end
            rng_ch.ready <= !receiver_stalls();
        end
    end

    task automatic put_byte(logic [7:0] b);
        hdr_buf.insert(hdr_buf.size(), b);
    endtask

    task automatic add_text(string s);
        for (int k = 0; k < s.len(); k++) begin
            put_byte(s[k]);
        end
    endtask

    // Queues the buffered header; an empty buffer always becomes a byteless transaction.
    task automatic send_header(logic [63:0] clen, bit force_gap);
        t_hdr_item it;
        bit        by_gap;
        int        n;
        by_gap = force_gap || hdr_buf.size() == 0 || $urandom_range(4) == 0;
        n      = hdr_buf.size();
        for (int k = 0; k < n; k++) begin
            it.ch   = hdr_buf[k];
            it.has  = 1'b1;
            it.fin  = (k == n - 1) && !by_gap;
            it.clen = it.fin ? clen : rand64();
            pending_bytes.insert(pending_bytes.size(), it);
        end
        items_queued = items_queued + n;
        if (by_gap) begin
            it.ch   = 8'($urandom_range(255));
            it.has  = 1'b0;
            it.fin  = 1'($urandom_range(1));
            it.clen = clen;
            pending_bytes.insert(pending_bytes.size(), it);
            items_queued = items_queued + 1;
        end
        hdr_buf.delete();
    endtask

    task automatic directed(string s, logic [63:0] clen);
        add_text(s);
        send_header(clen, 1'b0);
    endtask

    function automatic string dec_text(logic [63:0] v);
        string s;
        s = $sformatf("%0d", v);
        if ($urandom_range(9) == 0) begin
            s = {"00", s};
        end
        return s;
    endfunction

    function automatic logic [63:0] pick_size();
        case ($urandom_range(5))
            0:       return 64'd0;
            1:       return 64'd1;
            2:       return 64'($urandom_range(1, 1000));
            3:       return 64'($urandom);
            4:       return rand64();
            default: return SIZE_MAX - 64'($urandom_range(3));
        endcase
    endfunction

    function automatic logic [63:0] pick_offset(logic [63:0] clen);
        case ($urandom_range(4))
            0:       return 64'($urandom_range(20));
            1:       return (clen != 64'd0) ? rand64() % clen : 64'd0;
            2:       return clen + 64'($urandom_range(3));
            3:       return rand64();
            default: return clen - 64'd1;
        endcase
    endfunction

    task automatic build_good_range(logic [63:0] clen);
        logic [63:0] a;
        logic [63:0] b;
        add_text("bytes=");
        case ($urandom_range(2))
            0: begin
                a = pick_offset(clen);
                b = ($urandom_range(1) == 1) ? a + 64'($urandom_range(50)) : pick_offset(clen);
                add_text({dec_text(a), "-", dec_text(b)});
            end
            1: begin
                add_text({dec_text(pick_offset(clen)), "-"});
            end
            default: begin
                case ($urandom_range(2))
                    0:       b = 64'($urandom_range(5));
                    1:       b = pick_offset(clen);
                    default: b = rand64();
                endcase
                add_text({"-", dec_text(b)});
            end
        endcase
    endtask

    task automatic random_header();
        logic [63:0] clen;
        string       pfx;
        clen = pick_size();
        pfx  = "bytes=";
        if ($urandom_range(99) < 75) begin
            build_good_range(clen);
        end else begin
            case ($urandom_range(5))
                0: begin
                    repeat ($urandom_range(1, 10)) put_byte(8'($urandom_range(255)));
                end
                1: begin
                    build_good_range(clen);
                    hdr_buf[$urandom_range(hdr_buf.size() - 1)] = 8'($urandom_range(255));
                end
                2: begin
                    build_good_range(clen);
                    hdr_buf.insert($urandom_range(6, hdr_buf.size()), CHAR_COMMA);
                end
                3: begin
                    add_text(pfx.substr(0, $urandom_range(4)));
                    if ($urandom_range(1) == 1) begin
                        add_text("0-1");
                    end
                end
                4: begin
                    add_text(pfx);
                    if ($urandom_range(1) == 1) begin
                        add_text("-");
                    end
                    put_byte(8'($urandom_range(8'h31, 8'h39)));
                    repeat ($urandom_range(19, 21)) begin
                        put_byte(8'($urandom_range(8'h30, 8'h39)));
                    end
                    if ($urandom_range(1) == 1) begin
                        add_text({"-", dec_text(64'($urandom_range(99)))});
                    end
                end
                default: begin
                    add_text({pfx, ($urandom_range(1) == 1) ? "+" : "",
                              dec_text(64'($urandom_range(9))), "-",
                              dec_text(64'($urandom_range(99))), "-",
                              dec_text(64'($urandom_range(9)))});
                end
            endcase
        end
        send_header(clen, 1'b0);
    endtask

    task automatic wait_drained();
        while (items_accepted != items_queued || expected_ranges.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
        end
        $display("http_byte_range_parser verification failed");
        $finish;
    end

    initial begin
        int target;
        i_rst_n             = 1'b0;
        hdr_ch.valid        = 1'b0;
        hdr_ch.header_char  = '0;
        hdr_ch.has_char     = 1'b0;
        hdr_ch.last_char    = 1'b0;
        hdr_ch.content_size = '0;
        rng_ch.ready        = 1'b0;
        clear_parser();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_header(rand64(), 1'b1);
        send_header(rand64(), 1'b1);
        directed("bytes=0-0", 64'd1);
        directed("bytes=0-", 64'd0);
        directed("bytes=-5", 64'd3);
        directed("bytes=-5", 64'd0);
        directed("bytes=-0", 64'd10);
        directed("bytes=-", 64'd10);
        directed("bytes=5-3", 64'd10);
        directed("bytes=18446744073709551614-18446744073709551615", SIZE_MAX);
        directed("bytes=18446744073709551615-", SIZE_MAX);
        directed("bytes=18446744073709551616-", SIZE_MAX);
        directed("bytes=-18446744073709551615", 64'd7);
        directed("bytes=1-2-3", 64'd10);
        directed("bytes=1,2-3", 64'd10);
        directed("Bytes=0-1", 64'd10);
        directed("bytes=", 64'd10);
        directed("bytes=+1-2", 64'd10);
        directed("bytes=7-100", 64'd5);
        directed("bytes=2-100", 64'd5);
        directed("bytes=0-", SIZE_MAX);
        add_text("byt");
        send_header(64'd10, 1'b1);
        add_text("bytes=0-9");
        send_header(64'd20, 1'b1);
        add_text("bytes=1-");
        put_byte(8'hFF);
        send_header(64'd10, 1'b0);
        add_text("bytes=");
        put_byte(8'h00);
        add_text("-5");
        send_header(64'd10, 1'b0);
        wait_drained();

        for (int p = RUN_FREE; p <= BOTH_SLOW; p++) begin
            idle_mode = t_idle_mode'(p);
            target    = items_queued + PHASE_ITEMS;
            while (items_queued < target) begin
                random_header();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (bad_results == 0) begin
            $display("http_byte_range_parser verification clean");
        end else begin
            $display("http_byte_range_parser verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/hbrp_pkg.sv
rtl/hbrp_if.sv
rtl/http_byte_range_parser.sv
rtl/hbrp_checker.sv
tb/sv/tb_http_byte_range_parser.sv
